// File: hdl/bfpi_pkg.sv
`default_nettype none
package bfpi_pkg;

    // shared shift-add multiplier: multiplicand, multiplier and product widths
    localparam int MUL_A_W = 47;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // shared restoring divider: dividend and divisor widths
    localparam int DIV_N_W = 80;
    localparam int DIV_D_W = 53;

    localparam logic [46:0] IMAX       = {47{1'b1}};
    localparam logic [53:0] PMAG_CAP   = 54'd1 << 53;
    localparam logic [31:0] MICRO_MULT = 32'd1000000;
    localparam logic [24:0] ALPHA_ONE  = 25'd1 << 24;

    // configuration register indexes
    localparam logic [2:0] REG_CAPACITY = 3'd0;
    localparam logic [2:0] REG_TARGET   = 3'd1;
    localparam logic [2:0] REG_KP       = 3'd2;
    localparam logic [2:0] REG_KI       = 3'd3;
    localparam logic [2:0] REG_MAX_PPM  = 3'd4;
    localparam logic [2:0] REG_SMOOTH_T = 3'd5;
    localparam logic [2:0] REG_RATE     = 3'd6;

    // datapath operations, in execution order
    localparam logic [3:0] OP_M_EL    = 4'd0;
    localparam logic [3:0] OP_D_INC   = 4'd1;
    localparam logic [3:0] OP_D_LIM   = 4'd2;
    localparam logic [3:0] OP_M_KP    = 4'd3;
    localparam logic [3:0] OP_M_KI    = 4'd4;
    localparam logic [3:0] OP_REQ     = 4'd5;
    localparam logic [3:0] OP_M_NUM   = 4'd6;
    localparam logic [3:0] OP_M_TR    = 4'd7;
    localparam logic [3:0] OP_D_ALPHA = 4'd8;
    localparam logic [3:0] OP_DIFF    = 4'd9;
    localparam logic [3:0] OP_M_STEP  = 4'd10;

    localparam logic [1:0] KIND_COMB = 2'd0;
    localparam logic [1:0] KIND_MUL  = 2'd1;
    localparam logic [1:0] KIND_DIV  = 2'd2;

    typedef struct packed {
        logic       take;
        logic       mul_go;
        logic       div_go;
        logic       cap;
        logic       out_load;
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic hold;
        logic ki_zero;
        logic t_zero;
        logic mul_done;
        logic div_done;
    } t_stat;

    function automatic logic [1:0] op_kind(input logic [3:0] op);
        logic [1:0] k;
        case (op)
            OP_D_INC, OP_D_LIM, OP_D_ALPHA: k = KIND_DIV;
            OP_REQ, OP_DIFF:                k = KIND_COMB;
            default:                        k = KIND_MUL;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// File: hdl/bfpi_mul.sv
`default_nettype none
module bfpi_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [bfpi_pkg::MUL_A_W-1:0] i_a,
    input  wire logic [bfpi_pkg::MUL_B_W-1:0] i_b,
    output logic                               o_done,
    output logic [bfpi_pkg::MUL_P_W-1:0]      o_prod
);
    import bfpi_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic [MUL_P_W-1:0] r_a;
    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_B_W-1:0] r_b;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= MUL_P_W'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[MUL_P_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

// File: hdl/bfpi_div.sv
`default_nettype none
module bfpi_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [bfpi_pkg::DIV_N_W-1:0] i_num,
    input  wire logic [bfpi_pkg::DIV_D_W-1:0] i_den,
    output logic                               o_done,
    output logic [bfpi_pkg::DIV_N_W-1:0]      o_quot
);
    import bfpi_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_N_W-1:0] r_q;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    always_comb begin
        trial = {r_rem, r_q[DIV_N_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            r_q   <= {r_q[DIV_N_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// File: hdl/bfpi_ctrl.sv
`default_nettype none
module bfpi_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire bfpi_pkg::t_stat i_stat,
    output bfpi_pkg::t_cmd       o_cmd
);
    import bfpi_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [3:0] r_op;
    logic [3:0] n_op;
    logic       r_valid;
    logic       n_valid;
    logic [3:0] nxt_op;
    logic [1:0] kind;
    logic       advance;

    always_comb begin
        nxt_op = r_op + 4'd1;
        if (nxt_op == OP_D_LIM && i_stat.ki_zero) begin
            nxt_op = nxt_op + 4'd1;
        end
        if (nxt_op == OP_D_ALPHA && i_stat.t_zero) begin
            nxt_op = nxt_op + 4'd1;
        end
    end

    always_comb begin
        kind         = op_kind(r_op);
        n_state      = r_state;
        n_op         = r_op;
        n_valid      = r_valid;
        advance      = 1'b0;
        o_cmd        = '0;
        o_cmd.op     = r_op;
        o_cmd.take   = (r_state == S_IDLE) && i_in_valid;
        if (r_valid && i_out_ready) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_op    = OP_M_EL;
                n_state = i_stat.hold ? S_DONE : S_RUN;
            end
            S_RUN: begin
                if (kind == KIND_MUL) begin
                    o_cmd.mul_go = 1'b1;
                    n_state      = S_WAIT;
                end else if (kind == KIND_DIV) begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_WAIT;
                end else begin
                    o_cmd.cap = 1'b1;
                    advance   = 1'b1;
                end
            end
            S_WAIT: begin
                if ((kind == KIND_MUL && i_stat.mul_done) ||
                    (kind == KIND_DIV && i_stat.div_done)) begin
                    o_cmd.cap = 1'b1;
                    advance   = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (advance) begin
            if (r_op == OP_M_STEP) begin
                n_state = S_DONE;
            end else begin
                n_op    = nxt_op;
                n_state = S_RUN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_M_EL;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_valid;
endmodule
`default_nettype wire

// File: hdl/bfpi_dp.sv
`default_nettype none
module bfpi_dp #(
    parameter int FRAME_COUNT_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bfpi_pkg::t_cmd              i_cmd,
    output bfpi_pkg::t_stat                  o_stat,
    input  wire logic                        i_cfg_valid,
    input  wire logic [2:0]                  i_cfg_index,
    input  wire logic [31:0]                 i_cfg_data,
    input  wire logic [FRAME_COUNT_BITS-1:0] i_fill_frames,
    input  wire logic [FRAME_COUNT_BITS-1:0] i_elapsed_frames,
    output logic signed [32:0]               o_correction_ppm
);
    import bfpi_pkg::*;

    localparam int FB    = FRAME_COUNT_BITS;
    localparam int EW    = (FB > 16) ? FB : 16;
    localparam int MW    = EW + FB;
    localparam int NUM_W = FB + 20;

    // configuration
    logic [15:0] r_capacity;
    logic [15:0] r_target;
    logic [31:0] r_kp;
    logic [31:0] r_ki;
    logic [19:0] r_max_ppm;
    logic [23:0] r_smooth_t;
    logic [18:0] r_rate;

    // state
    logic signed [47:0] r_integ;
    logic signed [33:0] r_smooth;

    // per-item working registers
    logic [FB-1:0]      r_fill;
    logic [FB-1:0]      r_el;
    logic [MW-1:0]      r_m;
    logic [53:0]        r_pmag;
    logic [62:0]        r_imag;
    logic signed [33:0] r_req;
    logic [NUM_W-1:0]   r_num;
    logic [DIV_D_W-1:0] r_den;
    logic [24:0]        r_alpha;
    logic [34:0]        r_dmag;
    logic               r_dneg;
    logic signed [32:0] r_out;

    logic [EW-1:0]      bf;
    logic [EW-1:0]      tgt;
    logic               neg;
    logic [EW-1:0]      emag;
    logic [46:0]        integ_mag;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    logic [MUL_P_W-1:0] prod;
    logic [DIV_N_W-1:0] div_n;
    logic [DIV_D_W-1:0] div_d;
    logic               div_done;
    logic [DIV_N_W-1:0] quot;

    logic [46:0]        q_sat;
    logic signed [48:0] integ_sum;
    logic signed [47:0] integ_inc;
    logic signed [47:0] lim_s;
    logic signed [65:0] p_term;
    logic signed [65:0] i_term;
    logic signed [65:0] sum;
    logic signed [65:0] cap_s;
    logic signed [65:0] sum_c;
    logic [65:0]        sum_mag;
    logic [33:0]        req_mag;
    logic signed [34:0] diff;
    logic [34:0]        diff_mag;
    logic [34:0]        step;

    always_comb begin
        tgt       = EW'(r_target);
        bf        = (EW'(r_fill) < EW'(r_capacity)) ? EW'(r_fill) : EW'(r_capacity);
        neg       = tgt > bf;
        emag      = neg ? (tgt - bf) : (bf - tgt);
        integ_mag = r_integ[47] ? 47'(-r_integ) : 47'(r_integ);
    end

    always_comb begin
        mul_a = MUL_A_W'(emag);
        mul_b = MUL_B_W'(r_el);
        div_n = DIV_N_W'({r_m, 16'd0});
        div_d = DIV_D_W'(r_rate);
        case (i_cmd.op)
            OP_M_KP: begin
                mul_b = r_kp;
            end
            OP_M_KI: begin
                mul_a = integ_mag;
                mul_b = r_ki;
            end
            OP_M_NUM: begin
                mul_a = MUL_A_W'(r_el);
                mul_b = MICRO_MULT;
            end
            OP_M_TR: begin
                mul_a = MUL_A_W'(r_smooth_t);
                mul_b = MUL_B_W'(r_rate);
            end
            OP_M_STEP: begin
                mul_a = MUL_A_W'(r_dmag);
                mul_b = MUL_B_W'(r_alpha);
            end
            OP_D_LIM: begin
                div_n = DIV_N_W'({r_max_ppm, 32'd0});
                div_d = DIV_D_W'(r_ki);
            end
            OP_D_ALPHA: begin
                div_n = DIV_N_W'({r_num, 24'd0});
                div_d = r_den;
            end
            default: begin
            end
        endcase
    end

    bfpi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    bfpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        q_sat     = (|quot[DIV_N_W-1:47]) ? IMAX : quot[46:0];
        integ_inc = neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
        integ_sum = 49'(r_integ) + 49'(integ_inc);
        lim_s     = $signed({1'b0, q_sat});

        p_term  = $signed({12'd0, r_pmag});
        i_term  = $signed({3'd0, r_imag});
        sum     = (neg ? -p_term : p_term) + (r_integ[47] ? -i_term : i_term);
        cap_s   = $signed({30'd0, r_max_ppm, 16'd0});
        sum_c   = sum;
        if (sum > cap_s) begin
            sum_c = cap_s;
        end else if (sum < -cap_s) begin
            sum_c = -cap_s;
        end
        sum_mag = sum_c[65] ? 66'(-sum_c) : 66'(sum_c);
        req_mag = 34'(sum_mag[35:4]);

        diff     = 35'(r_req) - 35'(r_smooth);
        diff_mag = diff[34] ? 35'(-diff) : 35'(diff);
        step     = prod[58:24];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 16'd4096;
            r_target   <= 16'd2048;
            r_kp       <= 32'd65536;
            r_ki       <= 32'd6554;
            r_max_ppm  <= 20'd500;
            r_smooth_t <= 24'd100000;
            r_rate     <= 19'd48000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CAPACITY: r_capacity <= i_cfg_data[15:0];
                REG_TARGET:   r_target   <= i_cfg_data[15:0];
                REG_KP:       r_kp       <= i_cfg_data;
                REG_KI:       r_ki       <= i_cfg_data;
                REG_MAX_PPM:  r_max_ppm  <= i_cfg_data[19:0];
                REG_SMOOTH_T: r_smooth_t <= i_cfg_data[23:0];
                REG_RATE:     r_rate     <= i_cfg_data[18:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ  <= '0;
            r_smooth <= '0;
        end else if (i_cmd.cap) begin
            case (i_cmd.op)
                OP_D_INC: begin
                    if (integ_sum > $signed({2'b00, IMAX})) begin
                        r_integ <= $signed({1'b0, IMAX});
                    end else if (integ_sum < -$signed({2'b00, IMAX})) begin
                        r_integ <= -$signed({1'b0, IMAX});
                    end else begin
                        r_integ <= integ_sum[47:0];
                    end
                end
                OP_D_LIM: begin
                    if (r_integ > lim_s) begin
                        r_integ <= lim_s;
                    end else if (r_integ < -lim_s) begin
                        r_integ <= -lim_s;
                    end
                end
                OP_M_STEP: begin
                    r_smooth <= r_dneg ? 34'(r_smooth - 34'(step))
                                       : 34'(r_smooth + 34'(step));
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_fill <= i_fill_frames;
            r_el   <= i_elapsed_frames;
        end
        if (i_cmd.out_load) begin
            r_out <= r_smooth[32:0];
        end
        if (i_cmd.cap) begin
            case (i_cmd.op)
                OP_M_EL: r_m <= prod[MW-1:0];
                OP_M_KP: r_pmag <= (prod > MUL_P_W'(PMAG_CAP)) ? PMAG_CAP : prod[53:0];
                OP_M_KI: r_imag <= prod[MUL_P_W-1:16];
                OP_REQ:  r_req <= sum_c[65] ? -$signed(req_mag) : $signed(req_mag);
                OP_M_NUM: r_num <= prod[NUM_W-1:0];
                OP_M_TR: begin
                    r_den   <= DIV_D_W'(prod[42:0]) + DIV_D_W'(r_num);
                    r_alpha <= ALPHA_ONE;
                end
                OP_D_ALPHA: r_alpha <= quot[24:0];
                OP_DIFF: begin
                    r_dmag <= diff_mag;
                    r_dneg <= diff[34];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.hold     = (r_el == '0) || (r_rate == '0);
        o_stat.ki_zero  = (r_ki == '0);
        o_stat.t_zero   = (r_smooth_t == '0);
        o_stat.mul_done = mul_done;
        o_stat.div_done = div_done;
    end

    assign o_correction_ppm = r_out;
endmodule
`default_nettype wire

// File: hdl/buffer_fill_pi_rate_corrector_core.sv
`default_nettype none
// buffer-fill PI rate corrector
// input channel (i_in_valid / o_in_ready) takes one transaction per update: the
// ring-buffer fill level and the frames elapsed since the previous update.
// output channel (o_out_valid / i_out_ready) returns one transaction per input:
// the smoothed correction in ppm, signed Q20.12.
// config channel (i_cfg_valid / o_cfg_ready) writes one register per transaction,
// always ready; write only while no update is in flight.
// one update at a time: a hold update (zero elapsed frames or zero sample rate)
// skips the arithmetic and goes straight to the output register. a full update
// runs six passes of the shift-add multiplier and three passes of the restoring
// divider; zero ki or zero smoothing time drops one divider pass.
// the next input is taken once the previous result sits in the output register;
// if the receiver stalls, the finished result waits there and a following
// result waits in the sequencer until the register frees.
// reset (synchronous, active low) clears integral and smoothed correction and
// loads the register defaults.
module buffer_fill_pi_rate_corrector_core #(
    parameter int FRAME_COUNT_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [FRAME_COUNT_BITS-1:0] i_fill_frames,
    input  wire logic [FRAME_COUNT_BITS-1:0] i_elapsed_frames,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [32:0]               o_correction_ppm,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [2:0]                  i_cfg_index,
    input  wire logic [31:0]                 i_cfg_data
);
    import bfpi_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bfpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bfpi_dp #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_fill_frames    (i_fill_frames),
        .i_elapsed_frames (i_elapsed_frames),
        .o_correction_ppm (o_correction_ppm)
    );

    assign o_cfg_ready = 1'b1;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an update is in flight");

    a_single_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.mul_go && cmd.div_go))
        else $error("multiplier and divider started together");

    a_busy_on_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul_go |=> !o_in_ready)
        else $error("input ready while multiplier runs");

    a_load_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten while stalled");
endmodule
`default_nettype wire
